FILE: src/hrlp_pkg.sv
`default_nettype none
package hrlp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_URI    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_REQUEST = 2'd1;
  localparam logic [1:0] ST_NOT_IMPL    = 2'd2;
  localparam logic [1:0] ST_VERSION     = 2'd3;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  localparam logic [3:0] VERSION_LAST = 4'd9;

  // method names with their trailing space, padded with zeros
  localparam logic [7:0] METHOD_TEXT [8][8] = '{
    '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h48, 8'h45, 8'h41, 8'h44, 8'h20, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4f, 8'h53, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h55, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h44, 8'h45, 8'h4c, 8'h45, 8'h54, 8'h45, 8'h20, 8'h00},
    '{8'h43, 8'h4f, 8'h4e, 8'h4e, 8'h45, 8'h43, 8'h54, 8'h20},
    '{8'h4f, 8'h50, 8'h54, 8'h49, 8'h4f, 8'h4e, 8'h53, 8'h20},
    '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h20, 8'h00, 8'h00}
  };

  localparam logic [3:0] METHOD_LEN [8] = '{
    4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd8, 4'd6
  };

  localparam logic [7:0] VERSION_TEXT [10] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e, 8'h31, 8'h0d, 8'h0a
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] uri_byte;
    logic [1:0] status;
    logic [2:0] method;
  } result_t;

  function automatic logic hex_ok(input logic [7:0] c);
    logic ok;
    ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
         (c >= 8'h41 && c <= 8'h46);
    return ok;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - CH_DIGIT0;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - CH_LOWER_A + 8'd10;
    end else begin
      v = c - CH_UPPER_A + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/http_request_line_parser.sv
// http request line parser
// input channel: in_valid / in_stall carrying in_byte and in_end_of_request,
// one byte of the request each; the end mark flags the last byte
// output channel: out_valid / out_stall carrying out_result_kind (0 uri
// byte, 1 status), out_uri_byte, out_parse_status and out_method_code
// one byte is taken per cycle while in_stall is low; each gives zero or one result
// a result passes a small queue and then the output register: the parser writes
// it into the queue when its byte is taken, and the output register loads it
// from the queue head when it is empty or its result is being taken
// throughput is one byte per cycle while the receiver keeps up
// when the receiver stalls, the output register holds its result and the
// queue (QUEUE_DEPTH entries) takes the overflow; in_stall rises once the
// queue is full and falls as soon as an entry leaves
// reset (rst_n low, synchronous) empties the queue and output register and
// puts the parser back at the start of a method name
// after the status of a request, bytes are ignored up to the end mark
`default_nettype none
module http_request_line_parser #(
  parameter int QUEUE_DEPTH = hrlp_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_request,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_result_kind,
  output logic [7:0]      out_uri_byte,
  output logic [1:0]      out_parse_status,
  output logic [2:0]      out_method_code
);

  hrlp_pkg::result_t fr_rec, q_head;
  logic fr_push, q_full, q_valid, q_pop, acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  hrlp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_byte),
    .in_end  (in_end_of_request),
    .rec     (fr_rec),
    .push    (fr_push)
  );

  hrlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_push),
    .wr_data   (fr_rec),
    .pop       (q_pop),
    .rd_data   (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  hrlp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_data           (q_head),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_uri_byte     (out_uri_byte),
    .out_parse_status (out_parse_status),
    .out_method_code  (out_method_code)
  );

endmodule
`default_nettype wire

FILE: src/hrlp_front.sv
`default_nettype none
module hrlp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_end,
  output hrlp_pkg::result_t      rec,
  output logic                   push
);

  typedef enum logic [5:0] {
    PH_METHOD  = 6'b000001,
    PH_URI     = 6'b000010,
    PH_HEX1    = 6'b000100,
    PH_HEX2    = 6'b001000,
    PH_VERSION = 6'b010000,
    PH_DRAIN   = 6'b100000
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cand_r, cand_nxt;
  logic [3:0] tpos_r, tpos_nxt;
  logic [3:0] hexhi_r, hexhi_nxt;
  logic       vmis_r, vmis_nxt;
  logic [2:0] meth_r, meth_nxt;

  logic [7:0] keep;
  logic       done;
  logic [2:0] done_m;
  logic [2:0] mpos;
  logic [3:0] vpos;
  logic       vmis_now;
  logic [7:0] dec;
  logic       st_emit, uri_emit;
  logic [1:0] st_code;
  logic [2:0] st_meth;
  logic [7:0] uri_val;

  always_comb begin
    mpos = tpos_r[2:0];
    keep = '0;
    done = 1'b0;
    done_m = '0;
    for (int m = 0; m < 8; m++) begin
      if (cand_r[m] && ({1'b0, mpos} < hrlp_pkg::METHOD_LEN[m]) &&
          hrlp_pkg::METHOD_TEXT[m][mpos] == in_byte) begin
        keep[m] = 1'b1;
        if ({1'b0, mpos} + 4'd1 == hrlp_pkg::METHOD_LEN[m]) begin
          done = 1'b1;
          done_m = 3'(m);
        end
      end
    end
  end

  assign vpos = (tpos_r > hrlp_pkg::VERSION_LAST) ? hrlp_pkg::VERSION_LAST : tpos_r;
  assign vmis_now = vmis_r | (hrlp_pkg::VERSION_TEXT[vpos] != in_byte);
  assign dec = {hexhi_r, hrlp_pkg::hex_val(in_byte)};

  always_comb begin
    phase_nxt = phase_r;
    cand_nxt  = cand_r;
    tpos_nxt  = tpos_r;
    hexhi_nxt = hexhi_r;
    vmis_nxt  = vmis_r;
    meth_nxt  = meth_r;
    st_emit   = 1'b0;
    st_code   = hrlp_pkg::ST_OK;
    st_meth   = meth_r;
    uri_emit  = 1'b0;
    uri_val   = in_byte;
    case (phase_r)
      PH_METHOD: begin
        if (keep == '0) begin
          st_emit = 1'b1;
          st_code = hrlp_pkg::ST_NOT_IMPL;
          st_meth = '0;
        end else if (done) begin
          meth_nxt = done_m;
          if (in_end) begin
            st_emit = 1'b1;
            st_code = hrlp_pkg::ST_BAD_REQUEST;
            st_meth = done_m;
          end else begin
            phase_nxt = PH_URI;
            tpos_nxt = '0;
          end
        end else begin
          cand_nxt = keep;
          tpos_nxt = {1'b0, mpos} + 4'd1;
          if (in_end) begin
            st_emit = 1'b1;
            st_code = hrlp_pkg::ST_BAD_REQUEST;
            st_meth = '0;
          end
        end
      end
      PH_URI: begin
        if (in_end) begin
          st_emit = 1'b1;
          st_code = hrlp_pkg::ST_BAD_REQUEST;
        end else if (in_byte == hrlp_pkg::CH_SPACE) begin
          phase_nxt = PH_VERSION;
          tpos_nxt = '0;
          vmis_nxt = 1'b0;
        end else if (in_byte == hrlp_pkg::CH_PERCENT) begin
          phase_nxt = PH_HEX1;
        end else begin
          uri_emit = 1'b1;
        end
      end
      PH_HEX1: begin
        if (!hrlp_pkg::hex_ok(in_byte) || in_end) begin
          st_emit = 1'b1;
          st_code = hrlp_pkg::ST_BAD_REQUEST;
        end else begin
          hexhi_nxt = hrlp_pkg::hex_val(in_byte);
          phase_nxt = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (!hrlp_pkg::hex_ok(in_byte) || in_end) begin
          st_emit = 1'b1;
          st_code = hrlp_pkg::ST_BAD_REQUEST;
        end else begin
          phase_nxt = PH_URI;
          // a decoded zero byte is dropped
          uri_emit = (dec != 8'h00);
          uri_val = dec;
        end
      end
      PH_VERSION: begin
        vmis_nxt = vmis_now;
        if (vpos == hrlp_pkg::VERSION_LAST) begin
          st_emit = 1'b1;
          st_code = vmis_now ? hrlp_pkg::ST_VERSION : hrlp_pkg::ST_OK;
        end else if (in_end) begin
          st_emit = 1'b1;
          st_code = hrlp_pkg::ST_BAD_REQUEST;
        end else begin
          tpos_nxt = vpos + 4'd1;
        end
      end
      default: begin
      end
    endcase
    if (st_emit) begin
      phase_nxt = PH_DRAIN;
    end
    // end mark starts the next request afresh
    if (in_end) begin
      phase_nxt = PH_METHOD;
      cand_nxt  = '1;
      tpos_nxt  = '0;
      hexhi_nxt = '0;
      vmis_nxt  = 1'b0;
      meth_nxt  = '0;
    end
  end

  always_comb begin
    push = acc && (st_emit || uri_emit);
    rec.kind     = st_emit ? hrlp_pkg::KIND_STATUS : hrlp_pkg::KIND_URI;
    rec.uri_byte = st_emit ? 8'h00 : uri_val;
    rec.status   = st_emit ? st_code : hrlp_pkg::ST_OK;
    rec.method   = st_emit ? st_meth : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      cand_r  <= '1;
      tpos_r  <= '0;
      hexhi_r <= '0;
      vmis_r  <= 1'b0;
      meth_r  <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      cand_r  <= cand_nxt;
      tpos_r  <= tpos_nxt;
      hexhi_r <= hexhi_nxt;
      vmis_r  <= vmis_nxt;
      meth_r  <= meth_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/hrlp_queue.sv
`default_nettype none
module hrlp_queue #(
  parameter int DEPTH = hrlp_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hrlp_pkg::result_t wr_data,
  input  wire logic              pop,
  output hrlp_pkg::result_t      rd_data,
  output logic                   not_empty,
  output logic                   full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  hrlp_pkg::result_t mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CW'(DEPTH));
  assign do_pop    = pop && not_empty;
  assign rd_data   = mem[rp_r];

  always_comb begin
    wp_nxt = push ? ((wp_r == LAST) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt = do_pop ? ((rp_r == LAST) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/hrlp_back.sv
`default_nettype none
module hrlp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hrlp_pkg::result_t q_data,
  input  wire logic              q_valid,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_result_kind,
  output logic [7:0]             out_uri_byte,
  output logic [1:0]             out_parse_status,
  output logic [2:0]             out_method_code
);

  logic              vld_r, vld_nxt;
  hrlp_pkg::result_t res_r;

  // refill the output register when it is empty or being taken
  assign q_pop   = q_valid && (!vld_r || !out_stall);
  assign vld_nxt = q_pop ? 1'b1 : (vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_data;
    end
  end

  assign out_valid        = vld_r;
  assign out_result_kind  = res_r.kind;
  assign out_uri_byte     = res_r.uri_byte;
  assign out_parse_status = res_r.status;
  assign out_method_code  = res_r.method;

endmodule
`default_nettype wire
